/* sv/tile_block_and_palette_allocator_macros.svh */
// Assertion macros for the tile block and palette allocator.
// Used by the top level; no other dependencies.
`ifndef TILE_BLOCK_AND_PALETTE_ALLOCATOR_MACROS_SVH
`define TILE_BLOCK_AND_PALETTE_ALLOCATOR_MACROS_SVH

`ifndef ASSERT_OFF

// a implies b in the same cycle, off during reset
`define TBPA_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("tbpa assertion failed");

// a implies b in the next cycle, off during reset
`define TBPA_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("tbpa assertion failed");

// a implies b in the next cycle, also checked across reset
`define TBPA_ASSERT_NEXT_ALWAYS(label, clk, a, b) \
  label: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("tbpa assertion failed");

`else

`define TBPA_ASSERT_IMPLY(label, clk, rst, a, b)
`define TBPA_ASSERT_NEXT(label, clk, rst, a, b)
`define TBPA_ASSERT_NEXT_ALWAYS(label, clk, a, b)

`endif

`endif

/* sv/tbpa_pkg.sv */
// Shared constants, codes and types of the tile block and palette allocator.
// No dependencies.
package tbpa_pkg;

  localparam int TILE_SLOTS      = 1024;
  localparam int PALETTE_SLOTS   = 16;
  localparam int MAX_BLOCK_TILES = 64;
  localparam int COUNT_W         = 16;

  // fixed field widths
  localparam int OP_W      = 2;
  localparam int PSLOT_W   = 4;
  localparam int TCOUNT_W  = 7;
  localparam int TSTART_W  = 10;
  localparam int STATUS_W  = 2;
  localparam int TBASE_W   = 10;

  // derived widths
  localparam int TILE_W = $clog2(TILE_SLOTS);
  localparam int PTR_W  = $clog2(TILE_SLOTS + MAX_BLOCK_TILES + 1);
  localparam int PAL_W  = (PALETTE_SLOTS > 1) ? $clog2(PALETTE_SLOTS) : 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_UNLOAD = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_PAL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_TILE = 2'd3;

  localparam logic [1:0] MARK_FREE = 2'd0;
  localparam logic [1:0] MARK_HEAD = 2'd1;
  localparam logic [1:0] MARK_CONT = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_MARK,
    S_UNL_RD,
    S_UNL_CHK,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic decide;
    logic clr_step;
    logic scan;
    logic mark_step;
    logic unl_read;
    logic unl_free;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic go_scan;
    logic go_unload;
    logic scan_found;
    logic scan_fail;
    logic mark_last;
    logic unl_end;
    logic unl_cont;
  } sts_t;

endpackage

/* sv/tbpa_ctrl.sv */
// Sequencer of the allocator: clearing pass, request decode, block scan,
// marking and unload walk. Depends on tbpa_pkg.
module tbpa_ctrl import tbpa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:   if (sts.clr_last) state_next = S_IDLE;
      S_IDLE:    if (in_valid) state_next = S_DECIDE;
      S_DECIDE: begin
        priority if (sts.go_scan) state_next = S_SCAN;
        else if (sts.go_unload)   state_next = S_UNL_RD;
        else                      state_next = S_FINISH;
      end
      S_SCAN: begin
        priority if (sts.scan_fail) state_next = S_FINISH;
        else if (sts.scan_found)    state_next = S_MARK;
        else                        state_next = S_SCAN;
      end
      S_MARK:    if (sts.mark_last) state_next = S_FINISH;
      S_UNL_RD:  state_next = sts.unl_end ? S_FINISH : S_UNL_CHK;
      S_UNL_CHK: state_next = sts.unl_cont ? S_UNL_RD : S_FINISH;
      S_FINISH:  if (out_free) state_next = S_IDLE;
      default:   state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd            = '0;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      S_CLEAR:   cmd.clr_step  = 1'b1;
      S_IDLE:    cmd.capture   = in_valid;
      S_DECIDE:  cmd.decide    = 1'b1;
      S_SCAN:    cmd.scan      = 1'b1;
      S_MARK:    cmd.mark_step = 1'b1;
      S_UNL_RD:  cmd.unl_read  = 1'b1;
      S_UNL_CHK: cmd.unl_free  = sts.unl_cont;
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

/* sv/tbpa_dp.sv */
// Datapath of the allocator: request registers, tile mark memory, scan
// pointers, palette reference counts and the result register. Depends on tbpa_pkg.
module tbpa_dp import tbpa_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic [OP_W-1:0]     op,
  input  logic                sprite_loaded,
  input  logic                palette_loaded,
  input  logic [PSLOT_W-1:0]  palette_slot,
  input  logic [TCOUNT_W-1:0] tile_count,
  input  logic [TSTART_W-1:0] tile_start,
  output logic [STATUS_W-1:0] status,
  output logic [TBASE_W-1:0]  tile_base,
  output logic [PSLOT_W-1:0]  palette_used,
  output logic                palette_assigned,
  output logic                palette_released
);

  // request
  logic [OP_W-1:0]     op_r;
  logic                sl_r;
  logic                pl_r;
  logic [PSLOT_W-1:0]  pslot_r;
  logic [TCOUNT_W-1:0] cnt_r;
  logic [TSTART_W-1:0] start_r;

  // scan and walk pointers
  logic [PAL_W-1:0] pal_r;
  logic [PTR_W-1:0] bstart;
  logic [PTR_W-1:0] raddr;
  logic [PTR_W-1:0] rchk;
  logic             rd_valid;

  logic [1:0] mem [TILE_SLOTS];
  logic [1:0] rd_data;

  logic [COUNT_W-1:0] pcount [PALETTE_SLOTS];

  // pending result
  logic [STATUS_W-1:0] res_status;
  logic [TBASE_W-1:0]  res_base;
  logic [PSLOT_W-1:0]  res_pal;
  logic                res_assigned;
  logic                res_released;

  logic [PTR_W-1:0]  n;
  logic [PTR_W-1:0]  bend;
  logic              is_load, is_unload, is_clear;
  logic              pslot_ok, count_ok, start_ok;
  logic [PAL_W-1:0]  pidx;
  logic [PAL_W-1:0]  free_idx;
  logic              any_zero;
  logic              have_pal;
  logic [PAL_W-1:0]  pal_pick;
  logic              rd_free, mismatch, found, scan_fail;
  logic              issue, unl_issue, rd_en;
  logic              we;
  logic [TILE_W-1:0] waddr;
  logic [1:0]        wdata;

  assign n         = PTR_W'(cnt_r);
  assign bend      = bstart + n;
  assign is_load   = (op_r == OP_LOAD) && !sl_r;
  assign is_unload = (op_r == OP_UNLOAD) && sl_r;
  assign is_clear  = (op_r == OP_CLEAR);
  assign pslot_ok  = 32'(pslot_r) < 32'(PALETTE_SLOTS);
  assign count_ok  = (cnt_r != '0) && (32'(cnt_r) <= 32'(MAX_BLOCK_TILES));
  assign start_ok  = 32'(start_r) < 32'(TILE_SLOTS);
  assign pidx      = PAL_W'(pslot_r);

  // lowest palette slot with no references
  always_comb begin
    free_idx = '0;
    any_zero = 1'b0;
    for (int p = PALETTE_SLOTS - 1; p >= 0; p--) begin
      if (pcount[p] == '0) begin
        free_idx = PAL_W'(p);
        any_zero = 1'b1;
      end
    end
  end

  assign have_pal = pl_r ? pslot_ok : any_zero;
  assign pal_pick = pl_r ? pidx : free_idx;

  // scan: one slot read per cycle, drop the in-flight read on a used slot
  assign scan_fail = bend > PTR_W'(TILE_SLOTS);
  assign rd_free   = (rd_data == MARK_FREE);
  assign mismatch  = rd_valid && !rd_free;
  assign found     = !scan_fail && rd_valid && rd_free && (rchk == bend - 1'b1);
  assign issue     = cmd.scan && !scan_fail && !mismatch && !found && (raddr < bend);
  assign unl_issue = cmd.unl_read && (raddr < PTR_W'(TILE_SLOTS));
  assign rd_en     = issue || unl_issue;

  always_comb begin
    sts.clr_last   = (raddr == PTR_W'(TILE_SLOTS - 1));
    sts.go_scan    = is_load && have_pal && count_ok;
    sts.go_unload  = is_unload && start_ok;
    sts.scan_found = found;
    sts.scan_fail  = scan_fail;
    sts.mark_last  = (raddr == bend - 1'b1);
    sts.unl_end    = (raddr >= PTR_W'(TILE_SLOTS));
    sts.unl_cont   = (rd_data == MARK_CONT);
  end

  // single write port
  always_comb begin
    we    = 1'b0;
    waddr = raddr[TILE_W-1:0];
    wdata = MARK_FREE;
    priority if (cmd.clr_step) begin
      we = 1'b1;
    end else if (cmd.decide && is_unload && start_ok) begin
      we    = 1'b1;
      waddr = TILE_W'(start_r);
    end else if (cmd.mark_step) begin
      we    = 1'b1;
      wdata = (raddr == bstart) ? MARK_HEAD : MARK_CONT;
    end else if (cmd.unl_free) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) rd_data <= mem[raddr[TILE_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= op;
      sl_r    <= sprite_loaded;
      pl_r    <= palette_loaded;
      pslot_r <= palette_slot;
      cnt_r   <= tile_count;
      start_r <= tile_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raddr    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (cmd.clr_step || cmd.mark_step || cmd.unl_free) raddr <= raddr + 1'b1;
      if (cmd.decide) begin
        rd_valid <= 1'b0;
        if (is_load) begin
          bstart <= n;
          raddr  <= n;
        end else if (is_unload) begin
          raddr <= PTR_W'(start_r) + 1'b1;
        end
      end
      if (cmd.scan) begin
        priority if (scan_fail) begin
          rd_valid <= 1'b0;
        end else if (mismatch) begin
          // advance to the next aligned block
          bstart   <= bend;
          raddr    <= bend;
          rd_valid <= 1'b0;
        end else if (found) begin
          raddr    <= bstart;
          rd_valid <= 1'b0;
        end else begin
          rd_valid <= issue;
          rchk     <= raddr;
          if (issue) raddr <= raddr + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < PALETTE_SLOTS; p++) pcount[p] <= '0;
    end else begin
      if (cmd.decide && is_clear) begin
        for (int p = 0; p < PALETTE_SLOTS; p++) pcount[p] <= '0;
      end
      if (cmd.decide && is_unload && pslot_ok && (pcount[pidx] != '0)) begin
        pcount[pidx] <= pcount[pidx] - 1'b1;
      end
      if (cmd.scan && found && (pcount[pal_r] != COUNT_MAX)) begin
        pcount[pal_r] <= pcount[pal_r] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      res_status   <= ST_IGNORED;
      res_base     <= '0;
      res_pal      <= '0;
      res_assigned <= 1'b0;
      res_released <= 1'b0;
      priority if (is_load) begin
        if (!have_pal) begin
          res_status <= ST_NO_PAL;
        end else begin
          res_status <= ST_NO_TILE;
          res_pal    <= PSLOT_W'(pal_pick);
          pal_r      <= pal_pick;
        end
      end else if (is_unload) begin
        res_status   <= ST_DONE;
        res_pal      <= pslot_r;
        res_released <= pslot_ok && (pcount[pidx] <= COUNT_W'(1));
      end else if (is_clear) begin
        res_status <= ST_DONE;
      end else begin
        res_status <= ST_IGNORED;
      end
    end
    if (cmd.scan && found) begin
      res_status   <= ST_DONE;
      res_base     <= TBASE_W'(bstart);
      res_assigned <= !pl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status           <= res_status;
      tile_base        <= res_base;
      palette_used     <= res_pal;
      palette_assigned <= res_assigned;
      palette_released <= res_released;
    end
  end

endmodule

/* sv/tile_block_and_palette_allocator.sv */
// Tile block and palette allocator, top level.
// Input channel (in_valid/in_stall) takes one request: load, unload or clear.
// Output channel (out_valid/out_stall) returns exactly one result per request.
// Load picks a palette slot, then scans the tile map for a free block aligned
// to tile_count, reading one tile mark per cycle from the tile mark memory;
// a used slot drops the read in flight and restarts at the next aligned block.
// Unload frees the head slot and the continuation slots that follow it.
// One request is in work at a time; the next one is taken at the earliest in
// the cycle after the previous result is loaded.
// After reset the tile map (TILE_SLOTS slots, 1024 here) is cleared one slot
// per cycle; in_stall stays high until that pass ends.
// A finished result sits in the output register while out_stall is high; the
// next request is taken meanwhile, and its result waits until the register
// is free.
// Depends on tbpa_pkg, tbpa_ctrl, tbpa_dp and the assertion macro header.
`include "tile_block_and_palette_allocator_macros.svh"

module tile_block_and_palette_allocator import tbpa_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OP_W-1:0]     op,
  input  logic                sprite_loaded,
  input  logic                palette_loaded,
  input  logic [PSLOT_W-1:0]  palette_slot,
  input  logic [TCOUNT_W-1:0] tile_count,
  input  logic [TSTART_W-1:0] tile_start,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic [TBASE_W-1:0]  tile_base,
  output logic [PSLOT_W-1:0]  palette_used,
  output logic                palette_assigned,
  output logic                palette_released
);

  cmd_t cmd;
  sts_t sts;

  tbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tbpa_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .op               (op),
    .sprite_loaded    (sprite_loaded),
    .palette_loaded   (palette_loaded),
    .palette_slot     (palette_slot),
    .tile_count       (tile_count),
    .tile_start       (tile_start),
    .status           (status),
    .tile_base        (tile_base),
    .palette_used     (palette_used),
    .palette_assigned (palette_assigned),
    .palette_released (palette_released)
  );

  // the clearing pass holds off requests right after reset
  `TBPA_ASSERT_NEXT_ALWAYS(a_clear_holds_input, clk, rst, in_stall)
  // one request at a time: busy right after taking one
  `TBPA_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  `TBPA_ASSERT_IMPLY(a_no_tile_clean, clk, rst, out_valid && status == ST_NO_TILE,
                     tile_base == '0 && !palette_assigned)
  `TBPA_ASSERT_IMPLY(a_release_is_unload, clk, rst, out_valid && palette_released,
                     status == ST_DONE && tile_base == '0 && !palette_assigned)

endmodule

/* tb/tile_block_and_palette_allocator_test.sv */
// Testbench for the tile block and palette allocator: directed and random requests
// are checked against a predictor of the tile map and the palette reference counts.
// Depends on tbpa_pkg and the tile_block_and_palette_allocator top level.
module tile_block_and_palette_allocator_test;
  import tbpa_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 8_000_000;
  localparam int LIVE_CAP = 40;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic                sprite_loaded;
    logic                palette_loaded;
    logic [PSLOT_W-1:0]  palette_slot;
    logic [TCOUNT_W-1:0] tile_count;
    logic [TSTART_W-1:0] tile_start;
  } alloc_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TBASE_W-1:0]  tile_base;
    logic [PSLOT_W-1:0]  palette_used;
    logic                palette_assigned;
    logic                palette_released;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] op = OP_CLEAR;
  logic sprite_loaded = 1'b0;
  logic palette_loaded = 1'b0;
  logic [PSLOT_W-1:0] palette_slot = '0;
  logic [TCOUNT_W-1:0] tile_count = '0;
  logic [TSTART_W-1:0] tile_start = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [TBASE_W-1:0] tile_base;
  logic [PSLOT_W-1:0] palette_used;
  logic palette_assigned;
  logic palette_released;

  // predictor state
  logic [1:0] tile_map [TILE_SLOTS];
  logic [COUNT_W-1:0] palette_refs [PALETTE_SLOTS];

  alloc_result_t expected_results [$];
  int live_bases [$];
  int live_palettes [$];
  int failures = 0;
  int cycles = 0;
  bit idle_enable = 1'b1;
  int stall_burst = 0;

  tile_block_and_palette_allocator DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .sprite_loaded(sprite_loaded), .palette_loaded(palette_loaded),
    .palette_slot(palette_slot), .tile_count(tile_count), .tile_start(tile_start),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .tile_base(tile_base), .palette_used(palette_used),
    .palette_assigned(palette_assigned), .palette_released(palette_released)
  );

  always #5 clk = ~clk;

  function automatic alloc_req_t make_req(logic [OP_W-1:0] o, logic sl, logic pl, int ps,
                                          int tc, int ts);
    alloc_req_t r;
    r.op = o;
    r.sprite_loaded = sl;
    r.palette_loaded = pl;
    r.palette_slot = PSLOT_W'(ps);
    r.tile_count = TCOUNT_W'(tc);
    r.tile_start = TSTART_W'(ts);
    return r;
  endfunction

  function automatic alloc_result_t allocate_or_release(alloc_req_t req);
    alloc_result_t res;
    int pal, base, n, s, i;
    bit have, found, free_run;
    res = '0;
    res.status = ST_IGNORED;
    if (req.op == OP_LOAD && !req.sprite_loaded) begin
      have = 1'b0;
      pal = 0;
      if (req.palette_loaded) begin
        if (req.palette_slot < PALETTE_SLOTS) begin
          pal = req.palette_slot;
          have = 1'b1;
        end
      end else begin
        for (int p = 0; p < PALETTE_SLOTS; p++)
          if (!have && palette_refs[p] == 0) begin
            pal = p;
            have = 1'b1;
          end
      end
      if (!have) begin
        res.status = ST_NO_PAL;
      end else begin
        res.palette_used = PSLOT_W'(pal);
        n = req.tile_count;
        found = 1'b0;
        base = 0;
        // aligned search from n up; a block may end exactly at the last slot
        if (n >= 1 && n <= MAX_BLOCK_TILES)
          for (s = n; s + n <= TILE_SLOTS && !found; s += n) begin
            free_run = 1'b1;
            for (i = s; i < s + n; i++)
              if (tile_map[i] != MARK_FREE) free_run = 1'b0;
            if (free_run) begin
              found = 1'b1;
              base = s;
            end
          end
        if (found) begin
          tile_map[base] = MARK_HEAD;
          for (i = base + 1; i < base + n; i++) tile_map[i] = MARK_CONT;
          if (palette_refs[pal] != COUNT_MAX) palette_refs[pal]++;
          res.status = ST_DONE;
          res.tile_base = TBASE_W'(base);
          res.palette_assigned = !req.palette_loaded;
        end else begin
          res.status = ST_NO_TILE;
        end
      end
    end else if (req.op == OP_UNLOAD && req.sprite_loaded) begin
      res.status = ST_DONE;
      res.palette_used = req.palette_slot;
      if (req.tile_start < TILE_SLOTS) begin
        tile_map[req.tile_start] = MARK_FREE;
        for (i = req.tile_start + 1; i < TILE_SLOTS && tile_map[i] == MARK_CONT; i++)
          tile_map[i] = MARK_FREE;
      end
      if (req.palette_slot < PALETTE_SLOTS) begin
        if (palette_refs[req.palette_slot] != 0) palette_refs[req.palette_slot]--;
        res.palette_released = (palette_refs[req.palette_slot] == 0);
      end
    end else if (req.op == OP_CLEAR) begin
      for (int p = 0; p < PALETTE_SLOTS; p++) palette_refs[p] = '0;
      res.status = ST_DONE;
    end
    return res;
  endfunction

  task automatic send_request(alloc_req_t req);
    alloc_result_t res;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= req.op;
    sprite_loaded <= req.sprite_loaded;
    palette_loaded <= req.palette_loaded;
    palette_slot <= req.palette_slot;
    tile_count <= req.tile_count;
    tile_start <= req.tile_start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = allocate_or_release(req);
    expected_results.push_back(res);
    if (req.op == OP_LOAD && res.status == ST_DONE) begin
      live_bases.push_back(res.tile_base);
      live_palettes.push_back(res.palette_used);
    end
  endtask

  // well-formed unload of a sprite that is still held
  task automatic unload_live(int idx);
    alloc_req_t req;
    req = make_req(OP_UNLOAD, 1'b1, 1'($urandom_range(0, 1)), live_palettes[idx],
                   $urandom_range(0, 127), live_bases[idx]);
    live_bases.delete(idx);
    live_palettes.delete(idx);
    send_request(req);
  endtask

  task automatic test_fill_and_exhaust();
    // fill every block of 64 with palettes 0..14, the last one ending at the top slot
    for (int p = 0; p < 15; p++)
      send_request(make_req(OP_LOAD, 1'b0, 1'b1, p, 64, $urandom_range(0, 1023)));
    send_request(make_req(OP_LOAD, 1'b0, 1'b1, 0, 64, 0));
    // picks palette 15, fails on tiles, then fits a single tile below the first block
    send_request(make_req(OP_LOAD, 1'b0, 1'b0, 3, 64, 0));
    send_request(make_req(OP_LOAD, 1'b0, 1'b0, 9, 1, 1023));
    send_request(make_req(OP_LOAD, 1'b0, 1'b0, 0, 2, 0));
  endtask

  task automatic test_special_requests();
    send_request(make_req(OP_LOAD, 1'b1, 1'b0, 5, 4, 100));
    send_request(make_req(OP_UNLOAD, 1'b0, 1'b1, 5, 4, 100));
    send_request(make_req(OP_UNUSED, 1'b1, 1'b1, 15, 127, 1023));
    send_request(make_req(OP_LOAD, 1'b0, 1'b1, 15, 0, 0));
    send_request(make_req(OP_LOAD, 1'b0, 1'b1, 15, 127, 0));
    send_request(make_req(OP_LOAD, 1'b0, 1'b1, 15, 65, 0));
    unload_live(14);
    // count already zero: hold at zero and report the release
    send_request(make_req(OP_UNLOAD, 1'b1, 1'b0, 14, 1, 1023));
    send_request(make_req(OP_CLEAR, 1'b0, 1'b0, 0, 0, 0));
    unload_live(14);
  endtask

  task automatic test_release_all();
    while (live_bases.size() > 0) unload_live($urandom_range(0, live_bases.size() - 1));
  endtask

  task automatic random_request();
    int roll, sel, tc, ps, pl;
    roll = $urandom_range(0, 99);
    if (live_bases.size() > LIVE_CAP) roll = 60;
    if (roll < 45) begin
      sel = $urandom_range(0, 9);
      tc = (sel < 6) ? $urandom_range(1, 4) : (sel < 9) ? $urandom_range(5, 16)
                                                        : $urandom_range(17, 64);
      pl = $urandom_range(0, 1);
      ps = $urandom_range(0, 15);
      if (pl && live_palettes.size() > 0 && $urandom_range(0, 1))
        ps = live_palettes[$urandom_range(0, live_palettes.size() - 1)];
      send_request(make_req(OP_LOAD, 1'b0, 1'(pl), ps, tc, $urandom_range(0, 1023)));
    end else if (roll < 80 && live_bases.size() > 0) begin
      unload_live($urandom_range(0, live_bases.size() - 1));
    end else begin
      case ($urandom_range(0, 5))
        0: send_request(make_req(OP_UNUSED, 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)),
                                 $urandom_range(0, 15), $urandom_range(0, 127),
                                 $urandom_range(0, 1023)));
        1: send_request(make_req(OP_CLEAR, 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)),
                                 $urandom_range(0, 15), $urandom_range(0, 127),
                                 $urandom_range(0, 1023)));
        2: send_request(make_req(OP_LOAD, 1'b1, 1'($urandom_range(0, 1)),
                                 $urandom_range(0, 15),
                                 $urandom_range(0, 127), $urandom_range(0, 1023)));
        3: send_request(make_req(OP_UNLOAD, 1'b0, 1'($urandom_range(0, 1)),
                                 $urandom_range(0, 15), $urandom_range(0, 127),
                                 $urandom_range(0, 1023)));
        4: send_request(make_req(OP_UNLOAD, 1'b1, 1'($urandom_range(0, 1)),
                                 $urandom_range(0, 15), $urandom_range(0, 127),
                                 $urandom_range(0, 1023)));
        default: send_request(make_req(OP_LOAD, 1'b0, 1'($urandom_range(0, 1)),
                                       $urandom_range(0, 15),
                                       $urandom_range(0, 1) ? 0 : $urandom_range(65, 127),
                                       $urandom_range(0, 1023)));
      endcase
    end
  endtask

  task automatic test_random_traffic(int count);
    for (int k = 0; k < count; k++) begin
      // alternate stretches with and without idling
      if (k % 60 == 0) idle_enable = ((k / 60) % 3 != 2);
      random_request();
    end
  endtask

  task automatic test_unstalled_tail(int count);
    idle_enable = 1'b0;
    for (int k = 0; k < count; k++) random_request();
  endtask

  // result stall: random bursts of out_stall
  always @(posedge clk) begin
    if (rst || !idle_enable) begin
      out_stall <= 1'b0;
      stall_burst = 0;
    end else if (stall_burst > 0) begin
      out_stall <= 1'b1;
      stall_burst--;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 5) == 0) stall_burst = $urandom_range(1, 4);
    end
  end

  always @(posedge clk) begin : check_results
    alloc_result_t exp;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result with no request pending, status %0d", status);
        failures++;
      end else begin
        exp = expected_results.pop_front();
        if (status !== exp.status) begin
          $error("status: expected %0d, got %0d", exp.status, status);
          failures++;
        end
        if (tile_base !== exp.tile_base) begin
          $error("tile_base: expected %0d, got %0d", exp.tile_base, tile_base);
          failures++;
        end
        if (palette_used !== exp.palette_used) begin
          $error("palette_used: expected %0d, got %0d", exp.palette_used, palette_used);
          failures++;
        end
        if (palette_assigned !== exp.palette_assigned) begin
          $error("palette_assigned: expected %0d, got %0d", exp.palette_assigned,
                 palette_assigned);
          failures++;
        end
        if (palette_released !== exp.palette_released) begin
          $error("palette_released: expected %0d, got %0d", exp.palette_released,
                 palette_released);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** tile_block_and_palette_allocator: FAILED **");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < TILE_SLOTS; i++) tile_map[i] = MARK_FREE;
    for (int p = 0; p < PALETTE_SLOTS; p++) palette_refs[p] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_fill_and_exhaust();
    test_special_requests();
    test_release_all();
    test_random_traffic(460);
    test_unstalled_tail(40);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (failures == 0)
      $display("** tile_block_and_palette_allocator: PASSED **");
    else
      $display("** tile_block_and_palette_allocator: FAILED **");
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/tbpa_pkg.sv
sv/tbpa_ctrl.sv
sv/tbpa_dp.sv
sv/tile_block_and_palette_allocator.sv
tb/tile_block_and_palette_allocator_test.sv
